FILE: sv/nan_fill_neighbor_average_defines.svh
// Assertion shorthands used by the top-level RTL file.
`ifndef NAN_FILL_NEIGHBOR_AVERAGE_DEFINES_SVH
`define NAN_FILL_NEIGHBOR_AVERAGE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define NFA_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define NFA_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define NFA_ASSERT_IMPL(name, clk, rst, ante, cons, msg)
`define NFA_ASSERT_NEXT(name, clk, rst, ante, cons, msg)

`endif

`endif

FILE: sv/nfa_pkg.sv
`timescale 1ns / 1ps

package nfa_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_DIM_DEF     = 128;
   localparam int HEIGHT_BITS_DEF = 16;

   // Fixed field widths
   localparam int CFG_BITS       = 8;
   localparam int POS_BITS       = 7;
   localparam int CSR_INDEX_BITS = 1;
   localparam int COUNT_BITS     = 4;   // number of valid cells in a window, up to nine

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAP_ROWS = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAP_COLS = 1'd1;

   localparam logic [CFG_BITS-1:0] MAP_DIM_RESET = 8'd100;

   // Divider status seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

FILE: sv/nan_fill_neighbor_average.sv
`timescale 1ns / 1ps
// 3x3 hole filler for an elevation map streamed in raster order, one cell per
// req item (height in Q8.8 with a valid flag; tuser high marks a flush tick
// that carries no cell). Each cell comes back on rsp one row and one column
// late, tagged with its row, column and a frame-last flag (tlast). An invalid
// interior cell is replaced by the mean of the valid cells of its 3x3 window,
// rounded to nearest with ties away from zero; with none valid it stays
// invalid. Border cells and valid cells pass unchanged, invalid heights read
// as zero. Send map_cols+1 flush items after the last cell to drain a frame.
// Timing: the block works on one item at a time. An item that yields no result
// passes IDLE, LOAD and EVAL; a passed-through cell adds EMIT, and a filled
// hole adds DIV before EMIT, the divider retiring four quotient bits a cycle.
// The rsp register frees the input side:
// a new item is taken while an earlier result still waits. Write map_rows or
// map_cols only between items; values outside 3..MAX_DIM are saturated. Line
// store entries are never cleared: an unwritten entry only reaches windows of
// border cells or of cells that are not emitted.

`include "nan_fill_neighbor_average_defines.svh"

module nan_fill_neighbor_average
   import nfa_pkg::*;
#(
   parameter  int MAX_DIM     = MAX_DIM_DEF,
   parameter  int HEIGHT_BITS = HEIGHT_BITS_DEF,
   localparam int REQ_BITS    = ((HEIGHT_BITS + 1 + 7) / 8) * 8,
   localparam int RSP_BITS    = ((HEIGHT_BITS + 1 + 2 * POS_BITS + 7) / 8) * 8
)
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_BITS-1:0]       req_tdata,   // cell_height, cell_valid, zero pad
   input  logic                      req_tuser,   // cmd

   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_BITS-1:0]       rsp_tdata,   // out_height, out_valid, out_row, out_col, pad
   output logic                      rsp_tlast,   // frame_last

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_data
);

   localparam int CELL_BITS = HEIGHT_BITS + 1;
   localparam int PSUM_BITS = HEIGHT_BITS + 2;
   localparam int SUM_BITS  = HEIGHT_BITS + 4;
   localparam int ADDR_BITS = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DIM_BITS  = $clog2(MAX_DIM + 1);
   localparam int CMP_BITS  = (DIM_BITS > CFG_BITS) ? DIM_BITS : CFG_BITS;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_LOAD = 5'b00010,
      ST_EVAL = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   // Saturate a frame dimension to 3..MAX_DIM
   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [CFG_BITS-1:0] d);
      logic [CMP_BITS-1:0] w;
      w = CMP_BITS'(d);
      if (w < CMP_BITS'(3)) return DIM_BITS'(3);
      if (w > CMP_BITS'(MAX_DIM)) return DIM_BITS'(MAX_DIM);
      return DIM_BITS'(w);
   endfunction

   state_type state_ff;
   state_type state_in;

   // Configuration
   logic [CFG_BITS-1:0] map_rows_ff;
   logic [CFG_BITS-1:0] map_cols_ff;
   logic [DIM_BITS-1:0] rows;
   logic [DIM_BITS-1:0] cols;

   // Input side
   logic [ADDR_BITS-1:0] in_col_ff;
   logic [1:0]           row_stage_ff;    // rows seen: zero, one, two or more
   logic [ADDR_BITS-1:0] col_eff;
   logic [ADDR_BITS-1:0] col_ff;
   logic [CELL_BITS-1:0] cur_ff;
   logic                 cur_valid;
   logic                 emit_ff;
   logic [DIM_BITS-1:0]  col_next;

   // Line store: older line above newer line
   logic [2*CELL_BITS-1:0] line_rd;
   logic [CELL_BITS-1:0]   top_cell;
   logic [CELL_BITS-1:0]   mid_cell;

   // Window chain
   logic [3*CELL_BITS-1:0]      col_d  [3];
   logic [3*CELL_BITS-1:0]      col_q  [3];
   logic signed [PSUM_BITS-1:0] psum_q [3];
   logic [1:0]                  vcnt_q [3];
   logic [CELL_BITS-1:0]        center;
   logic signed [SUM_BITS-1:0]  win_sum;
   logic [COUNT_BITS-1:0]       win_count;

   // Output side
   logic [ADDR_BITS-1:0] out_row_ff;
   logic [ADDR_BITS-1:0] out_col_ff;
   logic [DIM_BITS-1:0]  out_col_next;
   logic                 border;
   logic                 frame_end;
   logic                 fill;
   logic                 div_start;
   logic                 rsp_load;
   div_stat_type         div_stat;
   logic signed [HEIGHT_BITS-1:0] div_quo;

   logic [HEIGHT_BITS-1:0] res_height_ff;
   logic                   res_valid_ff;
   logic [ADDR_BITS-1:0]   res_row_ff;
   logic [ADDR_BITS-1:0]   res_col_ff;
   logic                   res_last_ff;

   logic                   rsp_tvalid_ff;
   logic [RSP_BITS-1:0]    rsp_tdata_ff;
   logic                   rsp_tlast_ff;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_rows_ff <= MAP_DIM_RESET;
         map_cols_ff <= MAP_DIM_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MAP_ROWS: map_rows_ff <= csr_data;
            CSR_MAP_COLS: map_cols_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign rows = clamp_dim(map_rows_ff);
   assign cols = clamp_dim(map_cols_ff);

   // ---------------------------------------------------------------- input
   // Restart the column if the width shrank below the running count.
   assign col_eff    = (DIM_BITS'(in_col_ff) >= cols) ? '0 : in_col_ff;
   assign cur_valid  = !req_tuser && req_tdata[HEIGHT_BITS];
   assign req_tready = (state_ff == ST_IDLE);
   assign col_next   = DIM_BITS'(col_ff) + 1'b1;

   // Take the item and latch its column; the line read goes out the same edge.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cur_ff <= cur_valid ? {1'b1, req_tdata[HEIGHT_BITS-1:0]} : '0;
         col_ff <= col_eff;
      end
   end

   nfa_line_buf #(
      .DEPTH (MAX_DIM),
      .WIDTH (2 * CELL_BITS)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (state_ff == ST_LOAD),
      .wr_addr (col_ff),
      .wr_data ({mid_cell, cur_ff}),
      .rd_addr (col_eff),
      .rd_data (line_rd)
   );

   assign top_cell = line_rd[2*CELL_BITS-1:CELL_BITS];
   assign mid_cell = line_rd[CELL_BITS-1:0];

   // ---------------------------------------------------------------- window
   // Rightmost column takes the fresh column; each cell hands its column left.
   assign col_d[2] = {cur_ff, mid_cell, top_cell};

   for (genvar k = 0; k < 3; k++) begin : g_cell
      if (k < 2) begin : g_link
         assign col_d[k] = col_q[k+1];
      end
      nfa_col_cell #(
         .HEIGHT_BITS (HEIGHT_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift      (state_ff == ST_LOAD),
         .col_in     (col_d[k]),
         .col_out    (col_q[k]),
         .psum_out   (psum_q[k]),
         .vcount_out (vcnt_q[k])
      );
   end

   assign center    = col_q[1][2*CELL_BITS-1:CELL_BITS];
   assign win_sum   = SUM_BITS'(psum_q[0]) + SUM_BITS'(psum_q[1]) + SUM_BITS'(psum_q[2]);
   assign win_count = COUNT_BITS'(vcnt_q[0]) + COUNT_BITS'(vcnt_q[1])
                    + COUNT_BITS'(vcnt_q[2]);

   // ---------------------------------------------------------------- result
   assign border = (out_row_ff == '0) || (DIM_BITS'(out_row_ff) >= rows - 1'b1)
                || (out_col_ff == '0) || (DIM_BITS'(out_col_ff) >= cols - 1'b1);
   assign frame_end = (DIM_BITS'(out_row_ff) >= rows - 1'b1)
                   && (DIM_BITS'(out_col_ff) >= cols - 1'b1);
   assign fill         = !center[HEIGHT_BITS] && !border;
   assign out_col_next = DIM_BITS'(out_col_ff) + 1'b1;

   nfa_hole_div #(
      .HEIGHT_BITS (HEIGHT_BITS)
   ) u_hole_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .sum      (win_sum),
      .count    (win_count),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!emit_ff) begin
               state_in = ST_IDLE;
            end else if (fill && (win_count != '0)) begin
               state_in  = ST_DIV;
               div_start = 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_DIV: begin
            if (div_stat.done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // Wait for the rsp register to free up
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Counters: advance the input position at LOAD, the output position at EVAL,
   // and rewind everything after the last cell of the frame.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_col_ff    <= '0;
         row_stage_ff <= '0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         emit_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_LOAD) begin
            emit_ff <= (row_stage_ff == 2'd2) || ((row_stage_ff == 2'd1) && (col_ff != '0));
            if (col_next >= cols) begin
               in_col_ff <= '0;
               if (row_stage_ff != 2'd2) row_stage_ff <= row_stage_ff + 2'd1;
            end else begin
               in_col_ff <= col_next[ADDR_BITS-1:0];
            end
         end
         if ((state_ff == ST_EVAL) && emit_ff) begin
            if (frame_end) begin
               in_col_ff    <= '0;
               row_stage_ff <= '0;
               out_row_ff   <= '0;
               out_col_ff   <= '0;
            end else if (out_col_next >= cols) begin
               out_col_ff <= '0;
               out_row_ff <= out_row_ff + 1'b1;
            end else begin
               out_col_ff <= out_col_next[ADDR_BITS-1:0];
            end
         end
      end
   end

   // Hold the pending result until the rsp register takes it.
   always_ff @(posedge clock) begin
      if ((state_ff == ST_EVAL) && emit_ff) begin
         res_valid_ff  <= center[HEIGHT_BITS];
         res_height_ff <= center[HEIGHT_BITS] ? center[HEIGHT_BITS-1:0] : '0;
         res_row_ff    <= out_row_ff;
         res_col_ff    <= out_col_ff;
         res_last_ff   <= frame_end;
      end else if ((state_ff == ST_DIV) && div_stat.done) begin
         res_valid_ff  <= 1'b1;
         res_height_ff <= div_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_tdata_ff <= RSP_BITS'({POS_BITS'(res_col_ff), POS_BITS'(res_row_ff),
                                    res_valid_ff, res_height_ff});
         rsp_tlast_ff <= res_last_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // ---------------------------------------------------------------- checks
   `NFA_ASSERT_IMPL(a_div_only_in_div, clock, reset, div_stat.busy || div_stat.done, state_ff == ST_DIV, "divider active outside DIV")
   `NFA_ASSERT_NEXT(a_accept_loads, clock, reset, req_tvalid && req_tready, state_ff == ST_LOAD, "accepted item not loaded")
   `NFA_ASSERT_NEXT(a_silent_item_idles, clock, reset, state_ff == ST_EVAL && !emit_ff, state_ff == ST_IDLE, "item without result did not return to idle")
   `NFA_ASSERT_NEXT(a_frame_rewind, clock, reset, state_ff == ST_EVAL && emit_ff && frame_end, out_row_ff == '0 && out_col_ff == '0 && row_stage_ff == 2'd0, "counters not rewound after frame end")

endmodule

FILE: sv/nfa_col_cell.sv
`timescale 1ns / 1ps

// One column of the 3x3 window: three cells, top lane lowest.
// Hold the column, plus its masked height sum and valid count, and hand
// them to the left neighbor on every shift.
module nfa_col_cell
   import nfa_pkg::*;
#(
   parameter  int HEIGHT_BITS = HEIGHT_BITS_DEF,
   localparam int CELL_BITS   = HEIGHT_BITS + 1,
   localparam int PSUM_BITS   = HEIGHT_BITS + 2
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        shift,
   input  logic [3*CELL_BITS-1:0]      col_in,
   output logic [3*CELL_BITS-1:0]      col_out,
   output logic signed [PSUM_BITS-1:0] psum_out,
   output logic [1:0]                  vcount_out
);

   logic [3*CELL_BITS-1:0]      col_ff;
   logic signed [PSUM_BITS-1:0] psum_ff;
   logic signed [PSUM_BITS-1:0] psum_in;
   logic [1:0]                  vcount_ff;
   logic [1:0]                  vcount_in;

   always_comb begin
      psum_in   = '0;
      vcount_in = '0;
      for (int k = 0; k < 3; k++) begin
         if (col_in[k*CELL_BITS + HEIGHT_BITS]) begin
            psum_in   = psum_in + PSUM_BITS'(signed'(col_in[k*CELL_BITS +: HEIGHT_BITS]));
            vcount_in = vcount_in + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         psum_ff   <= '0;
         vcount_ff <= '0;
      end else if (shift) begin
         col_ff    <= col_in;
         psum_ff   <= psum_in;
         vcount_ff <= vcount_in;
      end
   end

   assign col_out    = col_ff;
   assign psum_out   = psum_ff;
   assign vcount_out = vcount_ff;

endmodule

FILE: sv/nfa_line_buf.sv
`timescale 1ns / 1ps

// Line store: one write and one registered read per cycle.
module nfa_line_buf
   import nfa_pkg::*;
#(
   parameter  int DEPTH     = MAX_DIM_DEF,
   parameter  int WIDTH     = 2 * (HEIGHT_BITS_DEF + 1),
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] line_mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= line_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/nfa_hole_div.sv
`timescale 1ns / 1ps

// Rounded mean: |sum| + count/2 divided by count, four quotient bits a cycle,
// sign put back at the end (ties away from zero).
module nfa_hole_div
   import nfa_pkg::*;
#(
   parameter  int HEIGHT_BITS = HEIGHT_BITS_DEF,
   localparam int SUM_BITS    = HEIGHT_BITS + 4
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [SUM_BITS-1:0]    sum,
   input  logic [COUNT_BITS-1:0]         count,
   output div_stat_type                  stat,
   output logic signed [HEIGHT_BITS-1:0] quotient
);

   localparam int DIGITS    = 4;
   localparam int NUM_BITS  = ((SUM_BITS + DIGITS - 1) / DIGITS) * DIGITS;
   localparam int STEPS     = NUM_BITS / DIGITS;
   localparam int STEP_BITS = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic [NUM_BITS-1:0]   num_ff;
   logic [NUM_BITS-1:0]   num_in;
   logic [COUNT_BITS-1:0] rem_ff;
   logic [COUNT_BITS-1:0] rem_in;
   logic [COUNT_BITS-1:0] div_ff;
   logic                  neg_ff;
   logic [STEP_BITS-1:0]  step_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [SUM_BITS-1:0]   mag;
   logic [SUM_BITS-1:0]   biased;
   logic [HEIGHT_BITS-1:0] mag_q;

   assign mag    = sum[SUM_BITS-1] ? SUM_BITS'(-sum) : SUM_BITS'(sum);
   assign biased = mag + SUM_BITS'(count >> 1);

   // Restoring steps on a remainder that stays below the divisor
   always_comb begin : digit_steps
      logic [COUNT_BITS:0] trial;
      num_in = num_ff;
      rem_in = rem_ff;
      for (int i = 0; i < DIGITS; i++) begin
         trial = {rem_in, num_in[NUM_BITS-1]};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = COUNT_BITS'(trial - {1'b0, div_ff});
            num_in = {num_in[NUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = COUNT_BITS'(trial);
            num_in = {num_in[NUM_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_BITS'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= NUM_BITS'(biased);
         rem_ff <= '0;
         div_ff <= count;
         neg_ff <= sum[SUM_BITS-1];
      end else if (busy_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign mag_q     = num_ff[HEIGHT_BITS-1:0];
   assign quotient  = neg_ff ? -signed'(mag_q) : signed'(mag_q);
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

FILE: verif/tb_nan_fill_neighbor_average.sv
`timescale 1ns / 1ps

typedef struct packed {
   logic signed [15:0] height;
   logic               ok;
} map_cell_type;

typedef struct packed {
   logic signed [15:0] height;
   logic               ok;
   logic [6:0]         row;
   logic [6:0]         col;
   logic               last;
} filled_cell_type;

// Track the filler's window and counters, and hold the cells it must emit.
class fill_scoreboard;
   logic [7:0]      rows_reg;
   logic [7:0]      cols_reg;
   map_cell_type    older_line[128];
   map_cell_type    newer_line[128];
   map_cell_type    win[3][3];
   int              in_row;
   int              in_col;
   int              out_row;
   int              out_col;
   filled_cell_type filled_due[$];
   int              n_errors;

   function new();
      rows_reg = nfa_pkg::MAP_DIM_RESET;
      cols_reg = nfa_pkg::MAP_DIM_RESET;
      for (int i = 0; i < 128; i++) begin
         older_line[i] = '0;
         newer_line[i] = '0;
      end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            win[i][j] = '0;
      in_row   = 0;
      in_col   = 0;
      out_row  = 0;
      out_col  = 0;
      n_errors = 0;
   endfunction

   function int clamp_dim(logic [7:0] raw);
      if (raw < 8'd3) return 3;
      if (raw > 8'd128) return 128;
      return int'(raw);
   endfunction

   function void set_reg(logic [nfa_pkg::CSR_INDEX_BITS-1:0] idx, logic [7:0] val);
      if (idx == nfa_pkg::CSR_MAP_ROWS) rows_reg = val;
      else if (idx == nfa_pkg::CSR_MAP_COLS) cols_reg = val;
   endfunction

   function map_cell_type hole_mean();
      int           sum;
      int           cnt;
      int           mag;
      map_cell_type r;
      r   = '0;
      sum = 0;
      cnt = 0;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            if (win[i][j].ok) begin
               sum += $signed(win[i][j].height);
               cnt++;
            end
      if (cnt == 0) return r;
      mag      = (sum < 0) ? -sum : sum;
      mag      = (mag + cnt / 2) / cnt;
      r.height = 16'((sum < 0) ? -mag : mag);
      r.ok     = 1'b1;
      return r;
   endfunction

   function void note_cell(logic flush, logic [15:0] raw_h, logic raw_ok);
      int              rows;
      int              cols;
      int              c;
      map_cell_type    cur;
      map_cell_type    top;
      map_cell_type    mid;
      map_cell_type    res;
      filled_cell_type want;
      logic            emit;
      logic            border;
      logic            last;
      rows = clamp_dim(rows_reg);
      cols = clamp_dim(cols_reg);
      c    = in_col;
      if (c >= cols) c = 0;
      cur.ok     = !flush && raw_ok;
      cur.height = cur.ok ? raw_h : 16'sd0;
      top = older_line[c];
      mid = newer_line[c];
      older_line[c] = mid;
      newer_line[c] = cur;
      for (int k = 0; k < 3; k++) begin
         win[k][0] = win[k][1];
         win[k][1] = win[k][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = cur;
      emit = (in_row >= 2) || (in_row == 1 && c >= 1);
      c++;
      if (c >= cols) begin
         c = 0;
         if (in_row < 255) in_row++;
      end
      in_col = c;
      if (!emit) return;
      border = (out_row == 0) || (out_row >= rows - 1) || (out_col == 0) ||
               (out_col >= cols - 1);
      res = win[1][1];
      if (!res.ok && !border) res = hole_mean();
      if (!res.ok) res.height = 16'sd0;
      last = (out_row >= rows - 1) && (out_col >= cols - 1);
      want.height = res.height;
      want.ok     = res.ok;
      want.row    = 7'(out_row);
      want.col    = 7'(out_col);
      want.last   = last;
      filled_due  = {filled_due, want};
      if (last) begin
         in_row  = 0;
         in_col  = 0;
         out_row = 0;
         out_col = 0;
      end else begin
         out_col++;
         if (out_col >= cols) begin
            out_col = 0;
            out_row++;
         end
      end
   endfunction

   task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      n_errors++;
   endtask

   task check_cell(logic [31:0] data, logic last);
      filled_cell_type got;
      filled_cell_type want;
      got.height = data[15:0];
      got.ok     = data[16];
      got.row    = data[23:17];
      got.col    = data[30:24];
      got.last   = last;
      if (filled_due.size() == 0) begin
         report($sformatf("cell row %0d col %0d with none due", got.row, got.col));
         return;
      end
      want = filled_due.pop_front();
      if (got.height !== want.height || got.ok !== want.ok || got.row !== want.row ||
          got.col !== want.col || got.last !== want.last)
         report($sformatf("got h=%0d v=%0d r=%0d c=%0d last=%0d, want h=%0d v=%0d r=%0d c=%0d last=%0d",
                          got.height, got.ok, got.row, got.col, got.last,
                          want.height, want.ok, want.row, want.col, want.last));
   endtask
endclass

module tb_nan_fill_neighbor_average;
   import nfa_pkg::*;

   // Corner frame for a 3x3 map, one entry per item: {cmd, cell_valid, cell_height}.
   // Extreme heights around an invalid centre that carries a junk height, then a
   // drain of flush ticks mixed with extra pixels past the frame.
   localparam logic [17:0] CORNER_FRAME [13] = '{
      {1'b0, 1'b1, 16'h8000}, {1'b0, 1'b1, 16'h7fff}, {1'b0, 1'b1, 16'h8000},
      {1'b0, 1'b0, 16'h5a5a}, {1'b0, 1'b0, 16'hffff}, {1'b0, 1'b1, 16'h0001},
      {1'b0, 1'b0, 16'h0000}, {1'b0, 1'b1, 16'hffff}, {1'b0, 1'b1, 16'h8000},
      {1'b1, 1'b0, 16'h0000}, {1'b1, 1'b1, 16'h1234}, {1'b0, 1'b1, 16'h0064},
      {1'b0, 1'b0, 16'h7fff}
   };

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [23:0]               req_tdata  = '0;   // cell_height, cell_valid, zero pad
   logic                      req_tuser  = 1'b0; // cmd
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [31:0]               rsp_tdata;         // out_height, out_valid, out_row, out_col, pad
   logic                      rsp_tlast;         // frame_last
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [CFG_BITS-1:0]       csr_data   = '0;

   fill_scoreboard sb;
   int             items_sent = 0;
   int             idle_pct   = 20;   // chance in percent that an idle burst starts
   int             rsp_hold   = 0;

   always #6 clock = ~clock;

   nan_fill_neighbor_average u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Sample every handshake at the rising edge. Check results before noting the
   // item of the same edge: a result always belongs to an earlier item.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_cell(rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready) sb.note_cell(req_tuser, req_tdata[15:0], req_tdata[16]);
         if (csr_valid && csr_ready) sb.set_reg(csr_index, csr_data);
      end
   end

   // Stall the result side in bursts at random.
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
         rsp_hold = $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Present one item, maybe after an idle burst, and hold it until taken.
   task automatic send_item(input logic flush, input logic [15:0] h, input logic ok);
      int gap;
      @(negedge clock);
      if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  <= flush;
      req_tdata  <= {7'b0, ok, h};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic drop_req();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
      @(negedge clock);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait for every due cell, then give the last silent item time to retire.
   task automatic wait_drain();
      while (sb.filled_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Mix extremes, small values (frequent rounding ties) and full-range heights.
   function automatic logic [15:0] pick_height();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2, 3:    return 16'($urandom_range(0, 12) - 6);
         default: return 16'($urandom);
      endcase
   endfunction

   // Reconfigure while idle, then stream a frame (or a cut-off part of one) and
   // its drain. Drain items are flush ticks or extra pixels past the frame.
   task automatic run_frame(input logic [7:0] rows_raw, input logic [7:0] cols_raw,
                            input bit whole, input int valid_pct);
      int r;
      int c;
      int n;
      wait_drain();
      write_reg(CSR_MAP_ROWS, rows_raw);
      write_reg(CSR_MAP_COLS, cols_raw);
      r = sb.clamp_dim(rows_raw);
      c = sb.clamp_dim(cols_raw);
      n = whole ? r * c : int'($urandom_range(1, r * c));
      for (int i = 0; i < n; i++)
         send_item($urandom_range(0, 29) == 0, pick_height(),
                   $urandom_range(1, 100) <= valid_pct);
      if (whole)
         for (int i = 0; i <= c; i++)
            send_item(1'($urandom_range(0, 1)), pick_height(), 1'($urandom_range(0, 1)));
      drop_req();
   endtask

   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: out-of-range sizes saturate to a 3x3 map.
      write_reg(CSR_MAP_ROWS, 8'd0);
      write_reg(CSR_MAP_COLS, 8'd2);
      foreach (CORNER_FRAME[i])
         send_item(CORNER_FRAME[i][17], CORNER_FRAME[i][15:0], CORNER_FRAME[i][16]);
      // A frame with no valid cell at all, junk heights on every invalid pixel.
      for (int i = 0; i < 13; i++)
         send_item(i % 4 == 1, 16'($urandom), 1'b0);
      drop_req();

      // Small frames with varied hole density and idling; some are cut short so
      // the next size takes effect mid-frame.
      while (items_sent < 180) begin
         case ($urandom_range(0, 3))
            0:       idle_pct = 0;
            1:       idle_pct = 10;
            2:       idle_pct = 30;
            default: idle_pct = 60;
         endcase
         run_frame(8'($urandom_range(0, 10)), 8'($urandom_range(0, 10)),
                   $urandom_range(0, 3) != 0, int'($urandom_range(15, 95)));
      end

      // Widest frame, then the tallest one with no idling at all.
      idle_pct = 25;
      run_frame(8'd1, 8'd255, 1'b1, 70);
      idle_pct = 0;
      run_frame(8'd128, 8'd3, 1'b1, 60);

      wait_drain();
      if (sb.n_errors == 0 && sb.filled_due.size() == 0) begin
         $display("PASS nan_fill_neighbor_average");
      end else begin
         $display("FAIL nan_fill_neighbor_average");
      end
      $finish;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #3_000_000;
      $display("FAIL nan_fill_neighbor_average");
      $finish;
   end

endmodule
